// ===== rtl/core/smx_pkg.sv =====
`timescale 1ns / 1ps

package smx_pkg;

    // field widths of the channels
    localparam int OP_W     = 4;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int SLOT_W   = 13;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 9;
    localparam int CFG_IDX_W = 1;

    // default sizes
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_FRAC_BITS   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ROWEND    = 4'd0,
        OP_ENTRY     = 4'd1,
        OP_ADD       = 4'd2,
        OP_SET       = 4'd3,
        OP_GET       = 4'd4,
        OP_XWRITE    = 4'd5,
        OP_ROWMUL    = 4'd6,
        OP_DIRICHLET = 4'd7,
        OP_RHSWRITE  = 4'd8,
        OP_RHSREAD   = 4'd9,
        OP_CLEAR     = 4'd10
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] column_count;
    } cfg_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end
        if (v < lo) begin
            return 32'sh80000000;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/core/smx_ifs.sv =====
`timescale 1ns / 1ps

// request channel
interface smx_in_if import smx_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic [SLOT_W-1:0]        slot;
    logic signed [VAL_W-1:0]  operand_value;

    modport source (output valid, op, row, col, slot, operand_value, input ready);
    modport sink (input valid, op, row, col, slot, operand_value, output ready);
endinterface

// response channel
interface smx_out_if import smx_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  result_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

// register write channel
interface smx_cfg_if import smx_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CNT_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/smx_ram.sv =====
`timescale 1ns / 1ps

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/smx_ctrl.sv =====
`timescale 1ns / 1ps

module smx_ctrl import smx_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg_regs,
    smx_in_if.sink     req,
    smx_out_if.source  rsp
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int PW  = $clog2(MAX_ENTRIES + 1);
    localparam logic signed [VAL_W-1:0] ONE_VAL = 32'sd1 <<< FRAC_BITS;
    // clearing pass length after reset
    localparam int INIT_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IAW    = $clog2(INIT_N);

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_DECODE   = 15'b000000000000010,
        S_SPAN_LO  = 15'b000000000000100,
        S_SPAN_HI  = 15'b000000000001000,
        S_FIND     = 15'b000000000010000,
        S_MUL_E    = 15'b000000000100000,
        S_MUL_X    = 15'b000000001000000,
        S_MUL_A    = 15'b000000010000000,
        S_DIR_E    = 15'b000000100000000,
        S_DIR_R    = 15'b000001000000000,
        S_DIR_END  = 15'b000010000000000,
        S_RHS_RD   = 15'b000100000000000,
        S_CLEAR    = 15'b001000000000000,
        S_FIN      = 15'b010000000000000,
        S_INIT     = 15'b100000000000000
    } state_t;

    function automatic logic [RAW-1:0] ridx(input logic [ROW_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[RAW-1:0];
    endfunction

    function automatic logic [CAW-1:0] cidx(input logic [COL_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[CAW-1:0];
    endfunction

    function automatic logic [EAW-1:0] sidx(input logic [SLOT_W-1:0] v);
        logic [16:0] w;
        w = 17'(v);
        return w[EAW-1:0];
    endfunction

    function automatic logic [PW-1:0] clamp_pos(input logic [SLOT_W-1:0] v);
        if (32'(v) > MAX_ENTRIES)
        begin
            return PW'(MAX_ENTRIES);
        end
        return PW'(v);
    endfunction

    state_t state_reg, state_next;

    // latched transaction
    op_t                     op_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic signed [VAL_W-1:0] opv_reg;

    // walk state
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           end_reg, end_next;
    logic [PW-1:0]           start_reg, start_next;
    logic [COL_W-1:0]        ecol_reg, ecol_next;
    logic signed [VAL_W-1:0] ev_reg, ev_next;
    logic                    xok_reg, xok_next;
    logic                    rok_reg, rok_next;
    logic signed [63:0]      prod_reg, prod_next;
    logic signed [63:0]      acc_reg, acc_next;
    logic                    diag_found_reg, diag_found_next;
    logic [EAW-1:0]          diag_pos_reg, diag_pos_next;
    logic [EAW-1:0]          clr_reg, clr_next;
    logic signed [VAL_W-1:0] res_reg, res_next;
    logic [STATUS_W-1:0]     st_reg, st_next;
    logic [IAW-1:0]          init_reg, init_next;

    // response register
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_load;

    // memory ports
    logic                    re_we;
    logic [RAW-1:0]          re_waddr, re_raddr;
    logic [SLOT_W-1:0]       re_wdata;
    logic [SLOT_W-1:0]       re_rdata;
    logic                    col_we;
    logic                    val_we;
    logic [EAW-1:0]          val_waddr;
    logic [VAL_W-1:0]        val_wdata;
    logic [EAW-1:0]          ent_raddr;
    logic [COL_W-1:0]        col_rdata;
    logic signed [VAL_W-1:0] val_rdata;
    logic                    x_we;
    logic [CAW-1:0]          x_waddr;
    logic [VAL_W-1:0]        x_wdata;
    logic [CAW-1:0]          x_raddr;
    logic signed [VAL_W-1:0] x_rdata;
    logic                    rhs_we;
    logic [RAW-1:0]          rhs_waddr, rhs_raddr;
    logic [VAL_W-1:0]        rhs_wdata;
    logic signed [VAL_W-1:0] rhs_rdata;

    // shared multiplier
    logic signed [VAL_W-1:0] mul_a, mul_b;

    logic                    row_ok, col_ok;
    logic [PW-1:0]           pos_inc;
    logic [PW-1:0]           span_s, span_e;
    logic signed [VAL_W-1:0] xv;
    logic signed [VAL_W-1:0] rhs_old;
    logic signed [63:0]      add_sum;
    logic signed [63:0]      acc_sum;

    smx_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ROWS)) u_row_end (
        .clk   (clk),
        .we    (re_we),
        .waddr (re_waddr),
        .wdata (re_wdata),
        .raddr (re_raddr),
        .rdata (re_rdata)
    );

    smx_ram #(.WIDTH(COL_W), .DEPTH(MAX_ENTRIES)) u_ent_col (
        .clk   (clk),
        .we    (col_we),
        .waddr (sidx(slot_reg)),
        .wdata (col_reg),
        .raddr (ent_raddr),
        .rdata (col_rdata)
    );

    smx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_ent_val (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (ent_raddr),
        .rdata (val_rdata)
    );

    smx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_x_vec (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    smx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_rhs_vec (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (rhs_waddr),
        .wdata (rhs_wdata),
        .raddr (rhs_raddr),
        .rdata (rhs_rdata)
    );

    assign row_ok  = ({1'b0, row_reg} < cfg_regs.row_count) && (32'(row_reg) < MAX_ROWS);
    assign col_ok  = ({1'b0, col_reg} < cfg_regs.column_count) && (32'(col_reg) < MAX_COLS);
    assign pos_inc = pos_reg + PW'(1);
    assign xv      = xok_reg ? x_rdata : '0;
    assign rhs_old = rhs_rdata;
    assign add_sum = 64'(val_rdata) + 64'(opv_reg);
    assign acc_sum = acc_reg + (prod_reg >>> FRAC_BITS);
    assign prod_next = mul_a * mul_b;

    // row span bounds from the row end table
    always_comb
    begin
        span_e = clamp_pos(re_rdata);
        span_s = (start_reg > span_e) ? span_e : start_reg;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        start_next      = start_reg;
        ecol_next       = ecol_reg;
        ev_next         = ev_reg;
        xok_next        = xok_reg;
        rok_next        = rok_reg;
        acc_next        = acc_reg;
        diag_found_next = diag_found_reg;
        diag_pos_next   = diag_pos_reg;
        clr_next        = clr_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        init_next       = init_reg;
        re_we           = 1'b0;
        re_waddr        = ridx(row_reg);
        re_wdata        = slot_reg;
        re_raddr        = ridx(row_reg);
        col_we          = 1'b0;
        val_we          = 1'b0;
        val_waddr       = sidx(slot_reg);
        val_wdata       = opv_reg;
        ent_raddr       = pos_reg[EAW-1:0];
        x_we            = 1'b0;
        x_waddr         = cidx(col_reg);
        x_wdata         = opv_reg;
        x_raddr         = cidx(col_rdata);
        rhs_we          = 1'b0;
        rhs_waddr       = ridx(row_reg);
        rhs_wdata       = opv_reg;
        rhs_raddr       = ridx(row_reg);
        mul_a           = ev_reg;
        mul_b           = xv;

        case (state_reg)
            S_INIT:
            begin
                // zero the row end, x and rhs stores after reset
                re_we     = 1'b1;
                re_waddr  = RAW'(init_reg);
                re_wdata  = '0;
                x_we      = 1'b1;
                x_waddr   = CAW'(init_reg);
                x_wdata   = '0;
                rhs_we    = 1'b1;
                rhs_waddr = RAW'(init_reg);
                rhs_wdata = '0;
                init_next = init_reg + IAW'(1);
                if (init_reg == IAW'(INIT_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next        = '0;
                st_next         = ST_OK;
                acc_next        = '0;
                diag_found_next = 1'b0;
                clr_next        = '0;
                state_next      = S_FIN;
                re_raddr        = ridx(row_reg - ROW_W'(1));
                start_next      = '0;
                case (op_reg)
                    OP_ROWEND:
                    begin
                        if (!row_ok || 32'(slot_reg) > MAX_ENTRIES)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            re_we = 1'b1;
                        end
                    end
                    OP_ENTRY:
                    begin
                        if (!col_ok || 32'(slot_reg) >= MAX_ENTRIES)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            col_we = 1'b1;
                            val_we = 1'b1;
                        end
                    end
                    OP_ADD, OP_SET, OP_GET:
                    begin
                        if (!row_ok || !col_ok)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_SPAN_LO;
                        end
                    end
                    OP_XWRITE:
                    begin
                        if (!col_ok)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            x_we = 1'b1;
                        end
                    end
                    OP_ROWMUL, OP_DIRICHLET:
                    begin
                        if (!row_ok)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_SPAN_LO;
                        end
                    end
                    OP_RHSWRITE:
                    begin
                        if (!row_ok)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            rhs_we = 1'b1;
                        end
                    end
                    OP_RHSREAD:
                    begin
                        if (!row_ok)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_RHS_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        st_next = ST_RANGE;
                    end
                endcase
            end

            S_SPAN_LO:
            begin
                // row zero starts at position zero
                if (row_reg == '0)
                begin
                    start_next = '0;
                end
                else
                begin
                    start_next = clamp_pos(re_rdata);
                end
                re_raddr   = ridx(row_reg);
                state_next = S_SPAN_HI;
            end

            S_SPAN_HI:
            begin
                pos_next  = span_s;
                end_next  = span_e;
                ent_raddr = span_s[EAW-1:0];
                if (span_s == span_e)
                begin
                    // empty row
                    case (op_reg)
                        OP_ADD, OP_SET:
                        begin
                            st_next    = ST_MISSING;
                            state_next = S_FIN;
                        end
                        OP_DIRICHLET:
                        begin
                            state_next = S_DIR_END;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
                else
                begin
                    case (op_reg)
                        OP_ROWMUL:
                        begin
                            state_next = S_MUL_E;
                        end
                        OP_DIRICHLET:
                        begin
                            state_next = S_DIR_E;
                        end
                        default:
                        begin
                            state_next = S_FIND;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                val_waddr = pos_reg[EAW-1:0];
                if (col_rdata == col_reg)
                begin
                    state_next = S_FIN;
                    case (op_reg)
                        OP_GET:
                        begin
                            res_next = val_rdata;
                        end
                        OP_SET:
                        begin
                            val_we = 1'b1;
                        end
                        default:
                        begin
                            val_we    = 1'b1;
                            val_wdata = sat32(add_sum);
                        end
                    endcase
                end
                else
                begin
                    pos_next  = pos_inc;
                    ent_raddr = pos_inc[EAW-1:0];
                    if (pos_inc == end_reg)
                    begin
                        state_next = S_FIN;
                        if (op_reg != OP_GET)
                        begin
                            st_next = ST_MISSING;
                        end
                    end
                end
            end

            S_MUL_E:
            begin
                ecol_next  = col_rdata;
                ev_next    = val_rdata;
                xok_next   = 32'(col_rdata) < MAX_COLS;
                x_raddr    = cidx(col_rdata);
                state_next = S_MUL_X;
            end

            S_MUL_X:
            begin
                mul_a      = ev_reg;
                mul_b      = xv;
                state_next = S_MUL_A;
            end

            S_MUL_A:
            begin
                acc_next  = acc_sum;
                pos_next  = pos_inc;
                ent_raddr = pos_inc[EAW-1:0];
                if (pos_inc == end_reg)
                begin
                    res_next   = sat32(acc_sum);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MUL_E;
                end
            end

            S_DIR_E:
            begin
                ecol_next = col_rdata;
                mul_a     = val_rdata;
                mul_b     = opv_reg;
                rok_next  = 32'(col_rdata) < MAX_ROWS;
                rhs_raddr = ridx(col_rdata);
                if (col_rdata == row_reg)
                begin
                    // diagonal entry: remember the last one
                    diag_found_next = 1'b1;
                    diag_pos_next   = pos_reg[EAW-1:0];
                    pos_next        = pos_inc;
                    ent_raddr       = pos_inc[EAW-1:0];
                    state_next      = (pos_inc == end_reg) ? S_DIR_END : S_DIR_E;
                end
                else
                begin
                    state_next = S_DIR_R;
                end
            end

            S_DIR_R:
            begin
                rhs_we    = rok_reg;
                rhs_waddr = ridx(ecol_reg);
                rhs_wdata = sat32(64'(rhs_old) - (prod_reg >>> FRAC_BITS));
                val_we    = 1'b1;
                val_waddr = pos_reg[EAW-1:0];
                val_wdata = '0;
                pos_next  = pos_inc;
                ent_raddr = pos_inc[EAW-1:0];
                state_next = (pos_inc == end_reg) ? S_DIR_END : S_DIR_E;
            end

            S_DIR_END:
            begin
                val_we     = diag_found_reg;
                val_waddr  = diag_pos_reg;
                val_wdata  = ONE_VAL;
                rhs_we     = 1'b1;
                state_next = S_FIN;
            end

            S_RHS_RD:
            begin
                res_next   = rhs_old;
                state_next = S_FIN;
            end

            S_CLEAR:
            begin
                val_we    = 1'b1;
                val_waddr = clr_reg;
                val_wdata = '0;
                clr_next  = clr_reg + EAW'(1);
                if (clr_reg == EAW'(MAX_ENTRIES - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            init_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= op_t'(req.op);
            row_reg  <= req.row;
            col_reg  <= req.col;
            slot_reg <= req.slot;
            opv_reg  <= req.operand_value;
        end
        pos_reg        <= pos_next;
        end_reg        <= end_next;
        start_reg      <= start_next;
        ecol_reg       <= ecol_next;
        ev_reg         <= ev_next;
        xok_reg        <= xok_next;
        rok_reg        <= rok_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        diag_found_reg <= diag_found_next;
        diag_pos_reg   <= diag_pos_next;
        clr_reg        <= clr_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        if (out_load)
        begin
            out_value_reg  <= (st_reg == ST_OK) ? res_reg : '0;
            out_status_reg <= st_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;

endmodule

// ===== rtl/core/sparse_csr_matrix_engine_unit.sv =====
`timescale 1ns / 1ps

// CSR sparse matrix engine: holds one assembled compressed-sparse-row matrix (row end
// table, entry columns and entry values), an x vector and a rhs vector, all Q16.16, and
// runs one operation per request transaction, answering with exactly one response
// transaction (value and status). Items are handled one at a time by a sequencer that
// works out of synchronous single-port-read memories. Get, set and add scan the row's
// entries up to the match; a row product takes each entry of the row through entry
// read, x read, multiply and accumulate; a Dirichlet row takes each off-diagonal entry
// through a second step that clears it and updates the rhs; clear sweeps every entry
// value position. A stalled response sink holds the sequencer in its finish state, and
// the sequencer returns to idle before the next request is taken. The rate is set by
// the one read port of the entry memory and the shared 32x32 multiplier. After reset a
// clearing pass over max(MAX_ROWS, MAX_COLS) positions (256 by default) zeroes the row
// end, x and rhs stores; no request is taken until it ends. A new request is taken
// while the previous response still waits in the output register. The user must see
// that registers are written over the cfg channel only while the block is idle; the
// block itself does not enforce it.
module sparse_csr_matrix_engine_unit import smx_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    smx_in_if.sink     req,
    smx_out_if.source  rsp,
    smx_cfg_if.sink    cfg
);

    // configuration registers
    cfg_t cfg_reg;

    // the register channel never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ROW_COUNT:
                begin
                    cfg_reg.row_count <= cfg.data;
                end
                CFG_COLUMN_COUNT:
                begin
                    cfg_reg.column_count <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer with the matrix and vector memories
    smx_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_smx_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .req      (req),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/core/smx_checker.sv =====
`timescale 1ns / 1ps

module smx_checker import smx_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic signed [VAL_W-1:0] rsp_result_value,
    input logic [STATUS_W-1:0]     rsp_status,
    input logic                    cfg_ready
);

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE
                       || rsp_status == ST_MISSING))
        else $error("undefined status code");

    // failed operations return zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != ST_OK) |-> (rsp_result_value == '0))
        else $error("nonzero value with error status");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while busy");

    // register channel is always open
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register channel stalled");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value)
                                       && $stable(rsp_status)))
        else $error("stalled response changed");

endmodule

bind sparse_csr_matrix_engine_unit smx_checker u_smx_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_status       (rsp.status),
    .cfg_ready        (cfg.ready)
);

// ===== sim/sparse_csr_matrix_engine_unit_test.sv =====
`timescale 1ns / 1ps

module sparse_csr_matrix_engine_unit_test;
    import smx_pkg::*;

    // q16.16 constants used by the stimulus
    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh00010000;

    // codes past the last operation
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd11;
    localparam logic [OP_W-1:0] OP_LAST_CODE    = 4'd15;

    // row 199 spans unwritten positions once row 200 is pointed at the top slot,
    // so no scan may ever address it
    localparam logic [ROW_W-1:0] LOOSE_ROW = 8'd199;
    localparam logic [ROW_W-1:0] TOP_ROW   = 8'd200;
    localparam int BUILT_ROWS = 16;

    // scoreboard: keeps its own copy of the matrix, vectors and counts
    class csr_scoreboard;
        logic [CNT_W-1:0]         rows_cfg;
        logic [CNT_W-1:0]         cols_cfg;
        logic [SLOT_W-1:0]        row_end[DEF_MAX_ROWS];
        logic [COL_W-1:0]         ent_col[DEF_MAX_ENTRIES];
        logic signed [VAL_W-1:0]  ent_val[DEF_MAX_ENTRIES];
        logic signed [VAL_W-1:0]  x_vec[DEF_MAX_COLS];
        logic signed [VAL_W-1:0]  rhs_vec[DEF_MAX_ROWS];
        logic signed [VAL_W-1:0]  want_value[$];
        logic [STATUS_W-1:0]      want_status[$];
        int fails;
        int checked;

        function new();
            rows_cfg = '0;
            cols_cfg = '0;
            foreach (row_end[i]) row_end[i] = '0;
            foreach (ent_col[i]) ent_col[i] = '0;
            foreach (ent_val[i]) ent_val[i] = '0;
            foreach (x_vec[i]) x_vec[i] = '0;
            foreach (rhs_vec[i]) rhs_vec[i] = '0;
            fails = 0;
            checked = 0;
        endfunction

        function int rows_used();
            return (rows_cfg < DEF_MAX_ROWS) ? int'(rows_cfg) : DEF_MAX_ROWS;
        endfunction

        function int cols_used();
            return (cols_cfg < DEF_MAX_COLS) ? int'(cols_cfg) : DEF_MAX_COLS;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            if (idx == CFG_ROW_COUNT) rows_cfg = data;
            else rows_cfg = rows_cfg;
            if (idx == CFG_COLUMN_COUNT) cols_cfg = data;
        endfunction

        // entry positions [s, e) of a row, clamped and never descending
        function void span(int r, output int s, output int e);
            s = (r == 0) ? 0 : int'(row_end[r-1]);
            e = int'(row_end[r]);
            if (s > DEF_MAX_ENTRIES) s = DEF_MAX_ENTRIES;
            if (e > DEF_MAX_ENTRIES) e = DEF_MAX_ENTRIES;
            if (s > e) s = e;
        endfunction

        function logic signed [VAL_W-1:0] clip(longint v);
            if (v > longint'(Q_MAX)) return Q_MAX;
            if (v < longint'(Q_MIN)) return Q_MIN;
            return v[VAL_W-1:0];
        endfunction

        // full 64-bit product, floor shift by the fraction width
        function longint qmul(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> DEF_FRAC_BITS;
        endfunction

        function int locate(int r, int c);
            int s;
            int e;
            span(r, s, e);
            for (int i = s; i < e; i++) begin
                if (int'(ent_col[i]) == c) return i;
            end
            return -1;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [ROW_W-1:0] r,
                                   logic [COL_W-1:0] c, logic [SLOT_W-1:0] slot,
                                   logic signed [VAL_W-1:0] v);
            bit row_ok;
            bit col_ok;
            logic signed [VAL_W-1:0] res;
            logic [STATUS_W-1:0] st;
            int pos;
            int s;
            int e;
            int diag;
            longint acc;
            row_ok = int'(r) < rows_used();
            col_ok = int'(c) < cols_used();
            res = '0;
            st = ST_OK;
            case (op)
                OP_ROWEND:
                    if (!row_ok || slot > DEF_MAX_ENTRIES) st = ST_RANGE;
                    else row_end[r] = slot;
                OP_ENTRY:
                    if (!col_ok || slot >= DEF_MAX_ENTRIES) st = ST_RANGE;
                    else
                    begin
                        ent_col[slot] = c;
                        ent_val[slot] = v;
                    end
                OP_ADD, OP_SET:
                    if (!row_ok || !col_ok) st = ST_RANGE;
                    else
                    begin
                        pos = locate(r, c);
                        if (pos < 0) st = ST_MISSING;
                        else if (op == OP_ADD) ent_val[pos] = clip(longint'(ent_val[pos]) + v);
                        else ent_val[pos] = v;
                    end
                OP_GET:
                    if (!row_ok || !col_ok) st = ST_RANGE;
                    else
                    begin
                        pos = locate(r, c);
                        if (pos >= 0) res = ent_val[pos];
                    end
                OP_XWRITE:
                    if (!col_ok) st = ST_RANGE;
                    else x_vec[c] = v;
                OP_ROWMUL:
                    if (!row_ok) st = ST_RANGE;
                    else
                    begin
                        acc = 0;
                        span(r, s, e);
                        for (int i = s; i < e; i++) acc += qmul(ent_val[i], x_vec[ent_col[i]]);
                        res = clip(acc);
                    end
                OP_DIRICHLET:
                    if (!row_ok) st = ST_RANGE;
                    else
                    begin
                        diag = -1;
                        span(r, s, e);
                        for (int i = s; i < e; i++) begin
                            if (ent_col[i] == r) diag = i;
                            else
                            begin
                                rhs_vec[ent_col[i]] = clip(longint'(rhs_vec[ent_col[i]])
                                                           - qmul(ent_val[i], v));
                                ent_val[i] = '0;
                            end
                        end
                        // only the last diagonal entry becomes one
                        if (diag >= 0) ent_val[diag] = Q_ONE;
                        rhs_vec[r] = v;
                    end
                OP_RHSWRITE:
                    if (!row_ok) st = ST_RANGE;
                    else rhs_vec[r] = v;
                OP_RHSREAD:
                    if (!row_ok) st = ST_RANGE;
                    else res = rhs_vec[r];
                OP_CLEAR:
                    foreach (ent_val[i]) ent_val[i] = '0;
                default:
                    st = ST_RANGE;
            endcase
            if (st != ST_OK) res = '0;
            want_value = {want_value, res};
            want_status = {want_status, st};
        endfunction

        function void check_response(logic signed [VAL_W-1:0] val, logic [STATUS_W-1:0] st);
            logic signed [VAL_W-1:0] ev;
            logic [STATUS_W-1:0] es;
            checked++;
            if (want_value.size() == 0) begin
                $error("response with nothing outstanding: result_value %0d status %0d", val, st);
                fails++;
                return;
            end
            ev = want_value.pop_front();
            es = want_status.pop_front();
            if (val !== ev) begin
                $error("result_value expected %0d actual %0d", ev, val);
                fails++;
            end
            if (st !== es) begin
                $error("status expected %0d actual %0d", es, st);
                fails++;
            end
        endfunction

        function int pending();
            return want_value.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    smx_in_if  req_if();
    smx_out_if rsp_if();
    smx_cfg_if cfg_if();

    sparse_csr_matrix_engine_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source),
        .cfg   (cfg_if.sink)
    );

    csr_scoreboard sb;

    // no idling on either side while set
    bit quiet;
    // positions [0, written_top) have all been written with an entry
    int written_top;
    int sent;
    int clears;
    int settings_run;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // response side: check every accepted transaction, stall at random
    always @(posedge clk)
    begin
        if (rst_n && sb != null && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.result_value, rsp_if.status);
        rsp_if.ready <= quiet || ($urandom_range(99) >= 16);
    end

    // hard stop in case the block hangs
    initial
    begin
        #100_000_000;
        $display("sparse_csr_matrix_engine_unit_test NOT OK");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return $signed(32'($urandom_range(0, 32'h0003ffff))) - 32'sh00020000;
            default: return $signed($urandom());
        endcase
    endfunction

    // any row that is safe to scan
    function automatic logic [ROW_W-1:0] pick_row();
        logic [ROW_W-1:0] r;
        if ($urandom_range(0, 3) != 0) r = ROW_W'($urandom_range(0, BUILT_ROWS));
        else r = ROW_W'($urandom_range(0, 255));
        if (r == LOOSE_ROW) r = TOP_ROW;
        return r;
    endfunction

    // column of a stored entry in the row when there is one, else any column
    function automatic logic [COL_W-1:0] pick_col(logic [ROW_W-1:0] r);
        int s;
        int e;
        sb.span(r, s, e);
        if (e > s && $urandom_range(0, 9) < 6)
            return sb.ent_col[$urandom_range(s, e - 1)];
        if (sb.cols_used() > 0 && $urandom_range(0, 3) != 0)
            return COL_W'($urandom_range(0, sb.cols_used() - 1));
        return COL_W'($urandom_range(0, 255));
    endfunction

    // one request transaction, at times with a random gap in front of it (never while quiet)
    task automatic issue(logic [OP_W-1:0] op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                         logic [SLOT_W-1:0] slot, logic signed [VAL_W-1:0] v);
        if (!quiet && $urandom_range(99) < 16) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.op            <= op;
        req_if.row           <= r;
        req_if.col           <= c;
        req_if.slot          <= slot;
        req_if.operand_value <= v;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_request(op, r, c, slot, v);
        if (op == OP_ENTRY && int'(c) < sb.cols_used() && int'(slot) == written_top)
            written_top++;
        if (op == OP_CLEAR) clears++;
        sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // stop sending until every response is in, then let the sequencer settle
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // lay out the low rows from position zero, a few entries each,
    // diagonal usually first and sometimes repeated
    task automatic build_rows();
        int k;
        int n;
        int pos;
        int cu;
        logic [COL_W-1:0] c;
        cu = sb.cols_used();
        k = (sb.rows_used() < BUILT_ROWS) ? sb.rows_used() : BUILT_ROWS;
        pos = 0;
        for (int r = 0; r < k; r++) begin
            n = (cu > 0) ? $urandom_range(0, 5) : 0;
            for (int j = 0; j < n; j++) begin
                c = COL_W'($urandom_range(0, cu - 1));
                if (r < cu && j == 0 && $urandom_range(0, 3) != 0) c = COL_W'(r);
                if (r < cu && j == n - 1 && j > 0 && $urandom_range(0, 4) == 0) c = COL_W'(r);
                issue(OP_ENTRY, ROW_W'($urandom()), c, SLOT_W'(pos), pick_value());
                pos++;
            end
            issue(OP_ROWEND, ROW_W'(r), COL_W'($urandom()), SLOT_W'(pos), pick_value());
        end
        if (pos > written_top) written_top = pos;
    endtask

    // top slot and the edges of every field, with the matrix just built
    task automatic directed_items();
        issue(OP_ENTRY, 8'd0, COL_W'(TOP_ROW), 13'd4095, Q_MAX);
        issue(OP_ROWEND, LOOSE_ROW, 8'd0, 13'd4095, '0);
        issue(OP_ROWEND, TOP_ROW, 8'd0, 13'd4096, '0);
        issue(OP_GET, TOP_ROW, COL_W'(TOP_ROW), '0, '0);
        issue(OP_XWRITE, 8'd0, COL_W'(TOP_ROW), '0, Q_MAX);
        issue(OP_XWRITE, 8'd0, 8'd255, '0, Q_MIN);
        issue(OP_ROWMUL, TOP_ROW, 8'd0, '0, '0);
        // saturating add
        issue(OP_ADD, TOP_ROW, COL_W'(TOP_ROW), '0, Q_MAX);
        // missing entry for add, set and get
        issue(OP_ADD, TOP_ROW, 8'd5, '0, Q_ONE);
        issue(OP_SET, TOP_ROW, 8'd7, '0, Q_ONE);
        issue(OP_GET, TOP_ROW, 8'd9, '0, '0);
        issue(OP_DIRICHLET, TOP_ROW, 8'd0, '0, Q_MIN);
        issue(OP_RHSREAD, TOP_ROW, 8'd0, '0, '0);
        issue(OP_RHSWRITE, 8'd255, 8'd0, '0, Q_MIN);
        issue(OP_RHSREAD, 8'd255, 8'd255, 13'h1fff, Q_MAX);
        // row end and entry slot past the store
        issue(OP_ROWEND, 8'd0, 8'd0, 13'd4097, '0);
        issue(OP_ROWEND, 8'd255, 8'd0, 13'h1fff, '0);
        issue(OP_ENTRY, 8'd0, 8'd3, 13'd4096, Q_ONE);
        issue(OP_GET, 8'd0, pick_col(8'd0), '0, '0);
        issue(OP_ROWMUL, 8'd3, 8'd0, '0, '0);
        issue(OP_DIRICHLET, 8'd2, 8'd0, '0, Q_ONE);
        issue(OP_LAST_CODE, 8'd1, 8'd1, '0, Q_ONE);
        issue(OP_FIRST_UNUSED, 8'd1, 8'd1, '0, Q_ONE);
        issue(OP_CLEAR, 8'd0, 8'd0, '0, '0);
        issue(OP_GET, TOP_ROW, COL_W'(TOP_ROW), '0, '0);
    endtask

    task automatic random_item();
        logic [ROW_W-1:0] r;
        logic [SLOT_W-1:0] slot;
        int pick;
        pick = $urandom_range(0, 99);
        r = pick_row();
        if (pick < 8) begin
            // in-range row ends stay within the written positions
            if ($urandom_range(0, 3) != 0)
                issue(OP_ROWEND, ROW_W'($urandom_range(0, BUILT_ROWS - 1)), COL_W'($urandom()),
                      SLOT_W'($urandom_range(0, written_top)), pick_value());
            else
                issue(OP_ROWEND, ROW_W'($urandom()), COL_W'($urandom()),
                      SLOT_W'($urandom_range(4097, 8191)), pick_value());
        end else if (pick < 18) begin
            if ($urandom_range(0, 4) != 0) slot = SLOT_W'($urandom_range(0, written_top));
            else slot = SLOT_W'($urandom_range(4096, 8191));
            issue(OP_ENTRY, ROW_W'($urandom()), pick_col(r), slot, pick_value());
        end else if (pick < 28) begin
            issue(OP_ADD, r, pick_col(r), SLOT_W'($urandom()), pick_value());
        end else if (pick < 36) begin
            issue(OP_SET, r, pick_col(r), SLOT_W'($urandom()), pick_value());
        end else if (pick < 48) begin
            issue(OP_GET, r, pick_col(r), SLOT_W'($urandom()), pick_value());
        end else if (pick < 58) begin
            issue(OP_XWRITE, ROW_W'($urandom()), pick_col(r), SLOT_W'($urandom()), pick_value());
        end else if (pick < 72) begin
            issue(OP_ROWMUL, r, COL_W'($urandom()), SLOT_W'($urandom()), pick_value());
        end else if (pick < 80) begin
            issue(OP_DIRICHLET, r, COL_W'($urandom()), SLOT_W'($urandom()), pick_value());
        end else if (pick < 87) begin
            // rhs access never scans, so any row goes
            issue(OP_RHSWRITE, ROW_W'($urandom()), COL_W'($urandom()), SLOT_W'($urandom()),
                  pick_value());
        end else if (pick < 95) begin
            issue(OP_RHSREAD, ROW_W'($urandom()), COL_W'($urandom()), SLOT_W'($urandom()),
                  pick_value());
        end else if (pick < 96) begin
            issue(OP_CLEAR, ROW_W'($urandom()), COL_W'($urandom()), SLOT_W'($urandom()),
                  pick_value());
        end else begin
            issue(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)), ROW_W'($urandom()),
                  COL_W'($urandom()), SLOT_W'($urandom()), pick_value());
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] rows_set[7];
        logic [CNT_W-1:0] cols_set[7];
        sb = new();
        quiet = 1'b0;
        written_top = 0;
        sent = 0;
        clears = 0;
        settings_run = 0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_ROWEND;
        req_if.row = '0;
        req_if.col = '0;
        req_if.slot = '0;
        req_if.operand_value = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ROW_COUNT;
        cfg_if.data = '0;
        // full size first, then empty, oversize, small, random and lopsided shapes
        rows_set = '{9'd256, 9'd0, 9'd511, 9'd17, 9'd0, 9'd3, 9'd256};
        cols_set = '{9'd256, 9'd0, 9'd300, 9'd9, 9'd0, 9'd256, 9'd2};
        rows_set[4] = CNT_W'($urandom_range(1, 256));
        cols_set[4] = CNT_W'($urandom_range(1, 256));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 7; p++) begin
            drain();
            // one full-rate stretch with no gaps on either side
            quiet = (p == 2);
            write_reg(CFG_ROW_COUNT, rows_set[p]);
            write_reg(CFG_COLUMN_COUNT, cols_set[p]);
            settings_run++;
            build_rows();
            if (p == 0) directed_items();
            repeat (180) random_item();
        end
        quiet = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("ran %0d request transactions over %0d register settings, %0d clears",
                 sent, settings_run, clears);
        $display("checked %0d response transactions, %0d mismatches", sb.checked, sb.fails);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("sparse_csr_matrix_engine_unit_test OK");
        else
            $display("sparse_csr_matrix_engine_unit_test NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/smx_pkg.sv
rtl/core/smx_ifs.sv
rtl/core/smx_ram.sv
rtl/core/smx_ctrl.sv
rtl/core/sparse_csr_matrix_engine_unit.sv
rtl/core/smx_checker.sv
sim/sparse_csr_matrix_engine_unit_test.sv
